### hw/rtl/hsv_threshold_centroid_assert.svh
// Assertion macros for the HSV threshold centroid block.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef HSV_THRESHOLD_CENTROID_ASSERT_SVH
`define HSV_THRESHOLD_CENTROID_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSTC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hstc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define HSTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hstc: next-cycle check failed");

`endif

### hw/rtl/hstc_pkg.sv
// ----------------------------------------------------------------------------
// hstc_pkg
// Shared types and constants of the HSV threshold centroid block.
// ----------------------------------------------------------------------------
package hstc_pkg;

  // Register map: byte address 4*index
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_HUE_LOW     = 3'd0;
  localparam logic [2:0] REG_SAT_LOW     = 3'd1;
  localparam logic [2:0] REG_VAL_LOW     = 3'd2;
  localparam logic [2:0] REG_HUE_HIGH    = 3'd3;
  localparam logic [2:0] REG_SAT_HIGH    = 3'd4;
  localparam logic [2:0] REG_VAL_HIGH    = 3'd5;
  localparam logic [2:0] REG_FRAME_WIDTH = 3'd6;

  // Reset values of the bound registers
  localparam logic [7:0] HUE_LOW_RST  = 8'd162;
  localparam logic [7:0] SAT_LOW_RST  = 8'd174;
  localparam logic [7:0] VAL_LOW_RST  = 8'd126;
  localparam logic [7:0] HUE_HIGH_RST = 8'd188;
  localparam logic [7:0] SAT_HIGH_RST = 8'd203;
  localparam logic [7:0] VAL_HIGH_RST = 8'd254;
  localparam int FRAME_WIDTH_RST = 320;

  typedef struct packed {
    logic [7:0] hue_low;
    logic [7:0] sat_low;
    logic [7:0] val_low;
    logic [7:0] hue_high;
    logic [7:0] sat_high;
    logic [7:0] val_high;
  } hstc_bounds_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_FIN
  } hstc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // pixel transfer this cycle
    logic frame_end;  // transferred pixel closes the frame
    logic div_step;   // one quotient bit for both dividers
    logic load_out;   // move quotients into the output register
  } hstc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;   // output register full and not taken this cycle
  } hstc_sts_t;

endpackage

### hw/rtl/hsv_threshold_centroid.sv
// ----------------------------------------------------------------------------
// hsv_threshold_centroid
// Pixels that are not last in frame: one transfer per cycle while input is not
// held off, no result. Last pixel: result valid once the bit-serial divider has
// run and the quotients are loaded into the output register; input is held off
// until that load, and longer while an earlier result still waits.
// Synchronous active-low reset clears counters, accumulators and output valid
// and restores the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`include "hsv_threshold_centroid_assert.svh"

module hsv_threshold_centroid #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hstc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_hue,
  input  logic [7:0]                  in_sat,
  input  logic [7:0]                  in_val,
  input  logic                        in_last_in_frame,
  // centroid result
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [COORD_BITS-1:0]       out_centroid_x,
  output logic [COORD_BITS-1:0]       out_centroid_y
);

  localparam int SUM_W = 3 * COORD_BITS + 1;

  hstc_pkg::hstc_bounds_t bounds;
  logic [COORD_BITS:0]    frame_width;
  hstc_pkg::hstc_cmd_t    cmd;
  hstc_pkg::hstc_sts_t    sts;

  hstc_regs #(
    .COORD_BITS (COORD_BITS)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .bounds      (bounds),
    .frame_width (frame_width)
  );

  hstc_ctrl #(
    .SUM_W (SUM_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_last_in_frame (in_last_in_frame),
    .in_ready         (in_ready),
    .sts              (sts),
    .cmd              (cmd)
  );

  hstc_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .bounds         (bounds),
    .frame_width    (frame_width),
    .in_hue         (in_hue),
    .in_sat         (in_sat),
    .in_val         (in_val),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_centroid_x (out_centroid_x),
    .out_centroid_y (out_centroid_y)
  );

  // a frame-end transfer holds off input while the divide runs
  `HSTC_ASSERT_NEXT(a_frame_end_stalls, in_valid && in_ready && in_last_in_frame, !in_ready)
  // an empty frame reports a zero centroid
  `HSTC_ASSERT_SAME(a_empty_zero, out_valid && !out_found, (out_centroid_x | out_centroid_y) == '0)
  // a result is never loaded over one that is still waiting
  `HSTC_ASSERT_SAME(a_no_overwrite, cmd.load_out, !(out_valid && !out_ready))

endmodule

### hw/rtl/hstc_regs.sv
// ----------------------------------------------------------------------------
// hstc_regs
// APB-style configuration registers: six HSV bounds and the frame width.
// ----------------------------------------------------------------------------
module hstc_regs #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hstc_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output hstc_pkg::hstc_bounds_t          bounds,
  output logic [COORD_BITS:0]             frame_width
);

  localparam int FW_W = COORD_BITS + 1;
  localparam int MAX_WIDTH = 1 << COORD_BITS;
  // Saturate the reset width so a narrow build keeps the same effective width
  localparam int FW_RST = (hstc_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                          MAX_WIDTH : hstc_pkg::FRAME_WIDTH_RST;

  hstc_pkg::hstc_bounds_t bounds_r;
  logic [FW_W-1:0]        fw_r;
  logic                   wr_en;
  logic [2:0]             reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[hstc_pkg::ADDR_W-1:2];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.hue_low  <= hstc_pkg::HUE_LOW_RST;
      bounds_r.sat_low  <= hstc_pkg::SAT_LOW_RST;
      bounds_r.val_low  <= hstc_pkg::VAL_LOW_RST;
      bounds_r.hue_high <= hstc_pkg::HUE_HIGH_RST;
      bounds_r.sat_high <= hstc_pkg::SAT_HIGH_RST;
      bounds_r.val_high <= hstc_pkg::VAL_HIGH_RST;
      fw_r              <= FW_W'(FW_RST);
    end else if (wr_en) begin
      case (reg_idx)
        hstc_pkg::REG_HUE_LOW:     bounds_r.hue_low  <= pwdata[7:0];
        hstc_pkg::REG_SAT_LOW:     bounds_r.sat_low  <= pwdata[7:0];
        hstc_pkg::REG_VAL_LOW:     bounds_r.val_low  <= pwdata[7:0];
        hstc_pkg::REG_HUE_HIGH:    bounds_r.hue_high <= pwdata[7:0];
        hstc_pkg::REG_SAT_HIGH:    bounds_r.sat_high <= pwdata[7:0];
        hstc_pkg::REG_VAL_HIGH:    bounds_r.val_high <= pwdata[7:0];
        hstc_pkg::REG_FRAME_WIDTH: fw_r              <= pwdata[FW_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      hstc_pkg::REG_HUE_LOW:     prdata = {24'd0, bounds_r.hue_low};
      hstc_pkg::REG_SAT_LOW:     prdata = {24'd0, bounds_r.sat_low};
      hstc_pkg::REG_VAL_LOW:     prdata = {24'd0, bounds_r.val_low};
      hstc_pkg::REG_HUE_HIGH:    prdata = {24'd0, bounds_r.hue_high};
      hstc_pkg::REG_SAT_HIGH:    prdata = {24'd0, bounds_r.sat_high};
      hstc_pkg::REG_VAL_HIGH:    prdata = {24'd0, bounds_r.val_high};
      hstc_pkg::REG_FRAME_WIDTH: prdata = 32'(fw_r);
      default:                   prdata = 32'd0;
    endcase
  end

  assign bounds      = bounds_r;
  assign frame_width = fw_r;

endmodule

### hw/rtl/hstc_ctrl.sv
// ----------------------------------------------------------------------------
// hstc_ctrl
// Frame controller: streams pixels, then sequences the centroid divide
// and the hand-off to the output register.
// ----------------------------------------------------------------------------
module hstc_ctrl #(
  parameter int SUM_W = 37
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_in_frame,
  output logic                in_ready,
  input  hstc_pkg::hstc_sts_t sts,
  output hstc_pkg::hstc_cmd_t cmd
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  hstc_pkg::hstc_state_t state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hstc_pkg::ST_RUN;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.frame_end = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.load_out  = 1'b0;
    case (state_r)
      hstc_pkg::ST_RUN: begin
        in_ready      = 1'b1;
        cmd.accept    = in_valid;
        cmd.frame_end = in_valid & in_last_in_frame;
        if (in_valid && in_last_in_frame) begin
          state_nxt = hstc_pkg::ST_DIV;
          step_nxt  = '0;
        end
      end
      hstc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = hstc_pkg::ST_FIN;
        end
      end
      hstc_pkg::ST_FIN: begin
        // wait until the output register can take the result
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = hstc_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = hstc_pkg::ST_RUN;
      end
    endcase
  end

endmodule

### hw/rtl/hstc_dp.sv
// ----------------------------------------------------------------------------
// hstc_dp
// Datapath: HSV band test, position counters, moment accumulators, two
// restoring dividers sharing one divisor, and the output register.
// ----------------------------------------------------------------------------
module hstc_dp #(
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hstc_pkg::hstc_cmd_t    cmd,
  output hstc_pkg::hstc_sts_t    sts,
  input  hstc_pkg::hstc_bounds_t bounds,
  input  logic [COORD_BITS:0]    frame_width,
  input  logic [7:0]             in_hue,
  input  logic [7:0]             in_sat,
  input  logic [7:0]             in_val,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [COORD_BITS-1:0]  out_centroid_x,
  output logic [COORD_BITS-1:0]  out_centroid_y
);

  localparam int C     = COORD_BITS;
  localparam int FW_W  = COORD_BITS + 1;
  localparam int CNT_W = 2 * COORD_BITS + 1;
  localparam int SUM_W = 3 * COORD_BITS + 1;
  localparam logic [FW_W-1:0] MAX_WIDTH = {1'b1, {COORD_BITS{1'b0}}};

  // Position and accumulators
  logic [C-1:0]     column_r, column_nxt;
  logic [C-1:0]     row_r, row_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_acc;
  logic [SUM_W-1:0] sum_x_r, sum_x_nxt, sum_x_acc;
  logic [SUM_W-1:0] sum_y_r, sum_y_nxt, sum_y_acc;

  // Divider registers
  logic [CNT_W-1:0] den_r;
  logic             found_r;
  logic [SUM_W-1:0] dx_r, dy_r;
  logic [CNT_W-1:0] rx_r, ry_r;
  logic [C-1:0]     qx_r, qy_r;

  // Output register
  logic             out_valid_r;
  logic             out_found_r;
  logic [C-1:0]     out_cx_r, out_cy_r;

  logic             match;
  logic [FW_W-1:0]  fw_eff;
  logic [FW_W-1:0]  col_inc;

  logic [CNT_W:0]   rx_sh, ry_sh, rx_diff, ry_diff;
  logic             x_ge, y_ge;

  // Inclusive band test on all three channels
  assign match = (in_hue >= bounds.hue_low) && (in_hue <= bounds.hue_high) &&
                 (in_sat >= bounds.sat_low) && (in_sat <= bounds.sat_high) &&
                 (in_val >= bounds.val_low) && (in_val <= bounds.val_high);

  // Accumulators including the current pixel
  assign count_acc = match ? count_r + CNT_W'(1) : count_r;
  assign sum_x_acc = match ? sum_x_r + SUM_W'(column_r) : sum_x_r;
  assign sum_y_acc = match ? sum_y_r + SUM_W'(row_r) : sum_y_r;

  // Width zero acts as one, oversize width is clamped
  always_comb begin
    if (frame_width == '0) begin
      fw_eff = FW_W'(1);
    end else if (frame_width > MAX_WIDTH) begin
      fw_eff = MAX_WIDTH;
    end else begin
      fw_eff = frame_width;
    end
  end

  assign col_inc = {1'b0, column_r} + FW_W'(1);

  // Next position and accumulator values
  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    count_nxt  = count_r;
    sum_x_nxt  = sum_x_r;
    sum_y_nxt  = sum_y_r;
    if (cmd.accept) begin
      if (cmd.frame_end) begin
        column_nxt = '0;
        row_nxt    = '0;
        count_nxt  = '0;
        sum_x_nxt  = '0;
        sum_y_nxt  = '0;
      end else begin
        count_nxt = count_acc;
        sum_x_nxt = sum_x_acc;
        sum_y_nxt = sum_y_acc;
        if (col_inc >= fw_eff) begin
          column_nxt = '0;
          row_nxt    = row_r + C'(1);
        end else begin
          column_nxt = col_inc[C-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
      count_r  <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
    end else begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      count_r  <= count_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
    end
  end

  // Restoring divide step: shift in one dividend bit, subtract if it fits
  assign rx_sh   = {rx_r, dx_r[SUM_W-1]};
  assign ry_sh   = {ry_r, dy_r[SUM_W-1]};
  assign rx_diff = rx_sh - {1'b0, den_r};
  assign ry_diff = ry_sh - {1'b0, den_r};
  assign x_ge    = rx_sh >= {1'b0, den_r};
  assign y_ge    = ry_sh >= {1'b0, den_r};

  // Divider load at frame end, one quotient bit per step; only the low
  // COORD_BITS of the quotient are kept
  always_ff @(posedge clk) begin
    if (cmd.frame_end) begin
      den_r   <= count_acc;
      found_r <= count_acc != '0;
      dx_r    <= sum_x_acc;
      dy_r    <= sum_y_acc;
      rx_r    <= '0;
      ry_r    <= '0;
      qx_r    <= '0;
      qy_r    <= '0;
    end else if (cmd.div_step) begin
      dx_r <= {dx_r[SUM_W-2:0], 1'b0};
      dy_r <= {dy_r[SUM_W-2:0], 1'b0};
      rx_r <= x_ge ? rx_diff[CNT_W-1:0] : rx_sh[CNT_W-1:0];
      ry_r <= y_ge ? ry_diff[CNT_W-1:0] : ry_sh[CNT_W-1:0];
      qx_r <= {qx_r[C-2:0], x_ge};
      qy_r <= {qy_r[C-2:0], y_ge};
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload, zero centroid when nothing matched
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found_r <= found_r;
      out_cx_r    <= found_r ? qx_r : '0;
      out_cy_r    <= found_r ? qy_r : '0;
    end
  end

  assign sts.out_busy   = out_valid_r & ~out_ready;
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_centroid_x = out_cx_r;
  assign out_centroid_y = out_cy_r;

endmodule
